// ----- hdl/slr_pkg.sv -----
// Shared types and constants of the SMBIOS structure lookup block.
package slr_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned HANDLE_W = 16;
   localparam int unsigned FIELD_W = 16;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned HEADER_BYTES = 4;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_FORMATTED,
      PH_STRINGS
   } phase_type;

   typedef enum logic {
      CSR_WANT_TYPE   = 1'b0,
      CSR_WANT_HANDLE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [FIELD_W-1:0] struct_offset;
      logic [FIELD_W-1:0] struct_length;
   } rsp_type;

endpackage

// ----- hdl/slr_intf.sv -----
// Valid/ready channel interfaces for the request and response words.
interface slr_req_if;
   logic             valid;
   logic             ready;
   slr_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface slr_rsp_if;
   logic             valid;
   logic             ready;
   slr_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/smbios_structure_lookup_top.sv -----
// SMBIOS structure table walker that reports the structure matching a type and handle.
//
// The block takes one table byte per request word and can accept a new word in
// every clock cycle; the parse state updates in the same cycle the word is accepted,
// and a response word it causes enters the output register at the same edge. Input is
// stalled only while that register holds a word the sink has not taken. At most one
// response word is given per region: found with offset and length, or not found at
// the byte marked last. Bytes at positions MAX_REGION_BYTES and above are not parsed.
// The want_type and want_handle registers should be written only while idle.
module smbios_structure_lookup_top #(
   parameter int unsigned MAX_REGION_BYTES = 65536
) (
   input  logic                             clock,
   input  logic                             reset,
   slr_req_if.sink                          req_chan,
   slr_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  slr_pkg::csr_index_type           csr_index,
   input  logic [slr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int unsigned POS_W = $clog2(MAX_REGION_BYTES + 1);
   localparam int unsigned LEN_W = (POS_W > slr_pkg::FIELD_W) ? POS_W : slr_pkg::FIELD_W;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_REGION_BYTES);

   logic [slr_pkg::BYTE_W-1:0]   want_type_ff;
   logic [slr_pkg::HANDLE_W-1:0] want_handle_ff;

   slr_pkg::phase_type           phase_ff, phase_in;
   logic [POS_W-1:0]             byte_position_ff, byte_position_in;
   logic [POS_W-1:0]             struct_start_ff, struct_start_in;
   logic [1:0]                   header_index_ff, header_index_in;
   logic [slr_pkg::BYTE_W-1:0]   seen_type_ff, seen_type_in;
   logic [slr_pkg::BYTE_W-1:0]   seen_length_ff, seen_length_in;
   logic [slr_pkg::HANDLE_W-1:0] seen_handle_ff, seen_handle_in;
   logic [slr_pkg::BYTE_W-1:0]   formatted_left_ff, formatted_left_in;
   logic                         previous_null_ff, previous_null_in;
   logic                         match_done_ff, match_done_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   slr_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic                         accept;
   logic                         res_valid;
   logic                         res_hit;
   logic                         wanted;
   logic [slr_pkg::BYTE_W-1:0]   b;
   logic                         lst;
   logic [LEN_W-1:0]             pos_ext;
   logic [LEN_W-1:0]             start_ext;
   logic [LEN_W-1:0]             len_full;
   logic [LEN_W-1:0]             len_short;
   logic [slr_pkg::BYTE_W-1:0]   fmt_len;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign b = req_chan.data.data_byte;
   assign lst = req_chan.data.last;
   assign wanted = (seen_type_ff == want_type_ff) && (seen_handle_ff == want_handle_ff);

   assign pos_ext = LEN_W'(byte_position_ff);
   assign start_ext = LEN_W'(struct_start_ff);
   assign len_full = pos_ext + LEN_W'(1) - start_ext;
   assign len_short = pos_ext - start_ext;

   assign fmt_len = (seen_length_ff < slr_pkg::BYTE_W'(slr_pkg::HEADER_BYTES)) ?
                    slr_pkg::BYTE_W'(slr_pkg::HEADER_BYTES) : seen_length_ff;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         want_type_ff <= '0;
         want_handle_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            slr_pkg::CSR_WANT_TYPE: begin
               want_type_ff <= csr_wdata[slr_pkg::BYTE_W-1:0];
            end
            slr_pkg::CSR_WANT_HANDLE: begin
               want_handle_ff <= csr_wdata[slr_pkg::HANDLE_W-1:0];
            end
            default: begin
               want_type_ff <= want_type_ff;
            end
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      byte_position_in = byte_position_ff;
      struct_start_in = struct_start_ff;
      header_index_in = header_index_ff;
      seen_type_in = seen_type_ff;
      seen_length_in = seen_length_ff;
      seen_handle_in = seen_handle_ff;
      formatted_left_in = formatted_left_ff;
      previous_null_in = previous_null_ff;
      match_done_in = match_done_ff;
      res_valid = 1'b0;
      res_hit = 1'b0;
      rsp_data_in = '0;

      if (accept) begin
         if (!match_done_ff && (byte_position_ff < POS_MAX)) begin
            case (phase_ff)
               slr_pkg::PH_HEADER: begin
                  case (header_index_ff)
                     2'd0: begin
                        struct_start_in = byte_position_ff;
                        seen_type_in = b;
                     end
                     2'd1: begin
                        seen_length_in = b;
                     end
                     2'd2: begin
                        seen_handle_in = slr_pkg::HANDLE_W'(b);
                     end
                     default: begin
                        seen_handle_in = {b, seen_handle_ff[slr_pkg::BYTE_W-1:0]};
                        formatted_left_in = fmt_len - slr_pkg::BYTE_W'(slr_pkg::HEADER_BYTES);
                        phase_in = (formatted_left_in != '0) ? slr_pkg::PH_FORMATTED :
                                                               slr_pkg::PH_STRINGS;
                        previous_null_in = 1'b0;
                     end
                  endcase
                  header_index_in = header_index_ff + 2'd1;
               end
               slr_pkg::PH_FORMATTED: begin
                  formatted_left_in = formatted_left_ff - slr_pkg::BYTE_W'(1);
                  if (formatted_left_in == '0) begin
                     phase_in = slr_pkg::PH_STRINGS;
                  end
               end
               slr_pkg::PH_STRINGS: begin
                  if ((b == '0) && previous_null_ff) begin
                     if (wanted) begin
                        res_valid = 1'b1;
                        res_hit = 1'b1;
                        rsp_data_in.struct_length = len_full[slr_pkg::FIELD_W-1:0];
                        match_done_in = 1'b1;
                     end else begin
                        phase_in = slr_pkg::PH_HEADER;
                        header_index_in = '0;
                        previous_null_in = 1'b0;
                     end
                  end else begin
                     previous_null_in = (b == '0);
                     if (lst && wanted) begin
                        res_valid = 1'b1;
                        res_hit = 1'b1;
                        rsp_data_in.struct_length = len_short[slr_pkg::FIELD_W-1:0];
                        match_done_in = 1'b1;
                     end
                  end
               end
               default: begin
                  phase_in = slr_pkg::PH_HEADER;
               end
            endcase
         end

         if (res_hit) begin
            rsp_data_in.found = 1'b1;
            rsp_data_in.struct_offset = start_ext[slr_pkg::FIELD_W-1:0];
         end

         if (lst) begin
            if (!res_valid && !match_done_ff) begin
               res_valid = 1'b1;
            end
            phase_in = slr_pkg::PH_HEADER;
            byte_position_in = '0;
            struct_start_in = '0;
            header_index_in = '0;
            seen_type_in = '0;
            seen_length_in = '0;
            seen_handle_in = '0;
            formatted_left_in = '0;
            previous_null_in = 1'b0;
            match_done_in = 1'b0;
         end else if (byte_position_ff < POS_MAX) begin
            byte_position_in = byte_position_ff + POS_W'(1);
         end
      end

      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= slr_pkg::PH_HEADER;
         byte_position_ff <= '0;
         struct_start_ff <= '0;
         header_index_ff <= '0;
         seen_type_ff <= '0;
         seen_length_ff <= '0;
         seen_handle_ff <= '0;
         formatted_left_ff <= '0;
         previous_null_ff <= 1'b0;
         match_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         byte_position_ff <= byte_position_in;
         struct_start_ff <= struct_start_in;
         header_index_ff <= header_index_in;
         seen_type_ff <= seen_type_in;
         seen_length_ff <= seen_length_in;
         seen_handle_ff <= seen_handle_in;
         formatted_left_ff <= formatted_left_in;
         previous_null_ff <= previous_null_in;
         match_done_ff <= match_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_no_second_hit: assert property (@(posedge clock) disable iff (reset)
      accept && match_done_ff |-> !res_valid)
      else $error("A second response word was produced after a match.");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.found |->
         (rsp_data_ff.struct_offset == '0) && (rsp_data_ff.struct_length == '0))
      else $error("A not-found word carries a nonzero offset or length.");

   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      byte_position_ff <= POS_MAX)
      else $error("The byte position ran past the region limit.");

   a_region_clear: assert property (@(posedge clock) disable iff (reset)
      accept && lst |=> (byte_position_ff == '0) && !match_done_ff &&
                        (phase_ff == slr_pkg::PH_HEADER))
      else $error("The parse state was not cleared after the last byte.");

endmodule

// ----- tb/tb_smbios_structure_lookup_top.sv -----
// Self-checking testbench for the SMBIOS structure lookup block with a byte-level predictor.
`timescale 1ns / 100ps

module tb_smbios_structure_lookup_top;

   class smbios_lookup_scoreboard;
      bit [7:0]            want_type;
      bit [15:0]           want_handle;
      int unsigned         region_limit;
      slr_pkg::phase_type  walk_phase;
      int unsigned         byte_pos;
      int unsigned         struct_start;
      bit [1:0]            hdr_idx;
      bit [7:0]            seen_type;
      bit [7:0]            seen_len;
      bit [7:0]            fmt_left;
      bit [15:0]           seen_handle;
      bit                  prev_null;
      bit                  match_done;
      slr_pkg::rsp_type    expected_words[$];
      int unsigned         mismatch_count;
      int unsigned         checked_count;

      function new(int unsigned limit);
         region_limit = limit;
         want_type = '0;
         want_handle = '0;
         mismatch_count = 0;
         checked_count = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         walk_phase = slr_pkg::PH_HEADER;
         byte_pos = 0;
         struct_start = 0;
         hdr_idx = '0;
         seen_type = '0;
         seen_len = '0;
         fmt_left = '0;
         seen_handle = '0;
         prev_null = 1'b0;
         match_done = 1'b0;
      endfunction

      function void set_register(slr_pkg::csr_index_type idx, bit [15:0] value);
         if (idx == slr_pkg::CSR_WANT_TYPE) begin
            want_type = value[7:0];
         end else begin
            want_handle = value;
         end
      endfunction

      function bit is_target();
         return seen_type == want_type && seen_handle == want_handle;
      endfunction

      // Advances the table walk by one word and queues the lookup answer it causes.
      function void note_byte(slr_pkg::req_type w);
         slr_pkg::rsp_type answer;
         bit               answered;
         int unsigned      span;
         answer = '0;
         answered = 1'b0;
         if (!match_done && byte_pos < region_limit) begin
            case (walk_phase)
               slr_pkg::PH_HEADER: begin
                  case (hdr_idx)
                     2'd0: begin
                        struct_start = byte_pos;
                        seen_type = w.data_byte;
                     end
                     2'd1: seen_len = w.data_byte;
                     2'd2: seen_handle = {8'h00, w.data_byte};
                     default: begin
                        seen_handle[15:8] = w.data_byte;
                        fmt_left = (seen_len < 8'd4) ? 8'd0 : seen_len - 8'd4;
                        walk_phase = (fmt_left != 0) ? slr_pkg::PH_FORMATTED :
                                                       slr_pkg::PH_STRINGS;
                        prev_null = 1'b0;
                     end
                  endcase
                  hdr_idx = hdr_idx + 2'd1;
               end
               slr_pkg::PH_FORMATTED: begin
                  fmt_left = fmt_left - 8'd1;
                  if (fmt_left == 0) begin
                     walk_phase = slr_pkg::PH_STRINGS;
                  end
               end
               default: begin
                  if (w.data_byte == 8'h00 && prev_null) begin
                     if (is_target()) begin
                        span = byte_pos + 1 - struct_start;
                        answer.found = 1'b1;
                        answer.struct_offset = struct_start[15:0];
                        answer.struct_length = span[15:0];
                        answered = 1'b1;
                        match_done = 1'b1;
                     end else begin
                        walk_phase = slr_pkg::PH_HEADER;
                        hdr_idx = '0;
                        prev_null = 1'b0;
                     end
                  end else begin
                     prev_null = (w.data_byte == 8'h00);
                     if (w.last && is_target()) begin
                        span = byte_pos - struct_start;
                        answer.found = 1'b1;
                        answer.struct_offset = struct_start[15:0];
                        answer.struct_length = span[15:0];
                        answered = 1'b1;
                        match_done = 1'b1;
                     end
                  end
               end
            endcase
         end
         if (w.last) begin
            if (!answered && !match_done) begin
               answer = '0;
               answered = 1'b1;
            end
            clear_parse();
         end else if (byte_pos < region_limit) begin
            byte_pos++;
         end
         if (answered) begin
            expected_words.push_back(answer);
         end
      endfunction

      function void check_result(slr_pkg::rsp_type got);
         slr_pkg::rsp_type want;
         checked_count++;
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected result word: found=%0d offset=%0d length=%0d",
                        got.found, got.struct_offset, got.struct_length);
            end
         end else begin
            want = expected_words.pop_front();
            if (got.found !== want.found || got.struct_offset !== want.struct_offset ||
                got.struct_length !== want.struct_length) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch: want found=%0d off=%0d len=%0d, got found=%0d off=%0d len=%0d",
                           want.found, want.struct_offset, want.struct_length,
                           got.found, got.struct_offset, got.struct_length);
               end
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   slr_pkg::csr_index_type csr_index;
   logic [slr_pkg::CSR_DATA_W-1:0] csr_wdata;

   slr_req_if req_bus ();
   slr_rsp_if rsp_bus ();

   smbios_structure_lookup_top #(
      .MAX_REGION_BYTES(65536)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   smbios_lookup_scoreboard sb;
   logic [7:0] region_bytes[$];
   int unsigned bytes_sent = 0;
   int unsigned regions_sent = 0;
   int unsigned burst_left = 0;
   bit hold_off_request = 1'b0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result(rsp_bus.data);
         end
         if (req_bus.valid && req_bus.ready) begin
            sb.note_byte(req_bus.data);
         end
      end
   end

   // Result sink: changing stall modes, plus one long hold-off when asked for.
   initial begin
      int mode;
      int mode_left;
      rsp_bus.ready <= 1'b0;
      mode = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (150) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   task automatic send_word(input logic [7:0] value, input logic is_last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_bus.valid <= 1'b1;
      req_bus.data <= '{data_byte: value, last: is_last};
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_region();
      for (int i = 0; i < region_bytes.size(); i++) begin
         send_word(region_bytes[i], i == region_bytes.size() - 1);
      end
      region_bytes.delete();
      regions_sent++;
   endtask

   task automatic add_struct(input bit [7:0] kind, input bit [7:0] len, input bit [15:0] handle,
                             input int strings);
      region_bytes.push_back(kind);
      region_bytes.push_back(len);
      region_bytes.push_back(handle[7:0]);
      region_bytes.push_back(handle[15:8]);
      repeat ((len < 8'd4) ? 0 : len - 4) region_bytes.push_back(8'($urandom_range(0, 255)));
      if (strings == 0) begin
         region_bytes.push_back(8'h00);
      end
      repeat (strings) begin
         repeat ($urandom_range(1, 6)) region_bytes.push_back(8'($urandom_range(1, 255)));
         region_bytes.push_back(8'h00);
      end
      region_bytes.push_back(8'h00);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_targets(input bit [7:0] kind, input bit [15:0] handle);
      bit [15:0] type_word;
      type_word = {8'($urandom_range(0, 255)), kind};
      csr_we <= 1'b1;
      csr_index <= slr_pkg::CSR_WANT_TYPE;
      csr_wdata <= type_word;
      sb.set_register(slr_pkg::CSR_WANT_TYPE, type_word);
      @(posedge clock);
      csr_index <= slr_pkg::CSR_WANT_HANDLE;
      csr_wdata <= handle;
      sb.set_register(slr_pkg::CSR_WANT_HANDLE, handle);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly well-formed tables around the target, some cut short, some plain noise.
   task automatic random_region();
      int pick;
      int cut;
      bit [7:0] kind;
      bit [7:0] len;
      bit [15:0] handle;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 20)) region_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 4)) begin
            kind = sb.want_type;
            handle = sb.want_handle;
            pick = $urandom_range(0, 5);
            case (pick)
               0, 1: ;
               2: handle = handle ^ (16'h0001 << $urandom_range(0, 15));
               3: kind = kind ^ (8'h01 << $urandom_range(0, 7));
               default: begin
                  kind = 8'($urandom_range(0, 255));
                  handle = 16'($urandom_range(0, 65535));
               end
            endcase
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
               len = 8'($urandom_range(0, 3));
            end else if (pick == 2) begin
               len = 8'd255;
            end else if (pick == 3) begin
               len = 8'($urandom_range(13, 254));
            end else begin
               len = 8'($urandom_range(4, 12));
            end
            add_struct(kind, len, handle, $urandom_range(0, 3));
         end
         if ($urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, region_bytes.size());
            while (region_bytes.size() > cut) void'(region_bytes.pop_back());
         end else begin
            repeat ($urandom_range(0, 3)) region_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
      send_region();
   endtask

   initial begin
      sb = new(65536);
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data <= '0;
      csr_we <= 1'b0;
      csr_index <= slr_pkg::CSR_WANT_TYPE;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_targets(8'hFF, 16'hFFFF);
      // Short formatted length, then a trailing word ignored after the match.
      region_bytes = '{8'hFF, 8'h02, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h5A};
      send_region();
      // Table cut off inside the header and inside the formatted area.
      region_bytes = '{8'hFF, 8'h04, 8'hFF};
      send_region();
      region_bytes = '{8'hFF, 8'h06, 8'hFF, 8'hFF, 8'h01};
      send_region();
      // Table cut off inside the string area of the target structure.
      region_bytes = '{8'hFF, 8'h04, 8'hFF, 8'hFF, 8'h41};
      send_region();
      region_bytes = '{8'h00};
      send_region();
      settle();
      write_targets(8'h00, 16'h0000);
      region_bytes = '{8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00};
      send_region();
      settle();

      for (int p = 0; p < 6; p++) begin
         if (p == 0) begin
            write_targets(8'h00, 16'h0000);
         end else if (p == 1) begin
            write_targets(8'hFF, 16'hFFFF);
         end else begin
            write_targets(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
         end
         if (p == 2) begin
            hold_off_request = 1'b1;
            repeat (40) begin
               region_bytes.push_back(8'($urandom_range(0, 255)));
               send_region();
            end
         end
         while (bytes_sent < 130 * (p + 1)) random_region();
         settle();
      end

      // A lone target structure with an empty string area.
      write_targets(8'h7E, 16'h1234);
      region_bytes = '{8'h7E, 8'h04, 8'h34, 8'h12, 8'h00, 8'h00};
      send_region();
      settle();
      repeat (8) @(posedge clock);

      $display("Walked %0d table regions (%0d words) under 9 target settings.",
               regions_sent, bytes_sent);
      $display("Checked %0d result words; %0d mismatches, %0d results missing.",
               sb.checked_count, sb.mismatch_count, sb.expected_words.size());
      if (sb.mismatch_count == 0 && sb.expected_words.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Timeout: result words still outstanding.");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
